// File: sv/rrps_pkg.sv
package rrps_pkg;

    localparam int DEF_CANVAS_WIDTH  = 128;
    localparam int DEF_CANVAS_HEIGHT = 128;
    localparam int CANVAS_CMP_W      = 11;

    localparam int QDEPTH = 4;
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam int QAW    = $clog2(QDEPTH);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_LEFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_TOP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_RADIUS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR    = 3'd5;

    localparam logic [6:0]  RST_RECT_LEFT     = 7'd10;
    localparam logic [6:0]  RST_RECT_TOP      = 7'd10;
    localparam logic [7:0]  RST_RECT_WIDTH    = 8'd80;
    localparam logic [7:0]  RST_RECT_HEIGHT   = 8'd80;
    localparam logic [6:0]  RST_CORNER_RADIUS = 7'd20;
    localparam logic [31:0] RST_FILL_COLOR    = 32'hFF0000FF;

    typedef struct packed {
        logic [6:0] col_offset;
        logic [6:0] row_offset;
    } t_in;

    typedef struct packed {
        logic [6:0] pix_x;
        logic [6:0] pix_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_out;

    typedef struct packed {
        logic [6:0]  rect_left;
        logic [6:0]  rect_top;
        logic [7:0]  rect_width;
        logic [7:0]  rect_height;
        logic [6:0]  corner_radius;
        logic [31:0] fill_color;
    } t_cfg;

    typedef struct packed {
        logic        scale;
        logic [7:0]  alpha;
        logic [13:0] dmin;
        logic [6:0]  px;
        logic [6:0]  py;
    } t_qent;

endpackage

// File: sv/rounded_rect_pixel_shader_unit.sv
// Rounded-rectangle pixel shader: takes one pixel offset per clock while o_stall is low and
// returns the canvas coordinate and fill colour when the offset lies inside the rounded shape
// and on the canvas; other offsets give no beat. Sustained rate is one pixel per clock while
// i_stall is low. A pixel takes one front classification stage, a 4-entry queue and 15 back
// stages (two multiplies, an 8-stage square root at two bits per stage, a 4-stage divide at
// two bits per stage, an output register). Configuration registers are written through the
// cfg port, always ready; the user must write them only while idle, unchecked by the block.
module rounded_rect_pixel_shader_unit
    import rrps_pkg::*;
#(
    parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in                  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out                 o_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cfg           r_cfg;
    logic           push, pop, q_nempty;
    t_qent          entry, head;
    logic [QCW-1:0] q_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rect_left     <= RST_RECT_LEFT;
            r_cfg.rect_top      <= RST_RECT_TOP;
            r_cfg.rect_width    <= RST_RECT_WIDTH;
            r_cfg.rect_height   <= RST_RECT_HEIGHT;
            r_cfg.corner_radius <= RST_CORNER_RADIUS;
            r_cfg.fill_color    <= RST_FILL_COLOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RECT_LEFT:     r_cfg.rect_left     <= i_cfg_data[6:0];
                CFG_RECT_TOP:      r_cfg.rect_top      <= i_cfg_data[6:0];
                CFG_RECT_WIDTH:    r_cfg.rect_width    <= i_cfg_data[7:0];
                CFG_RECT_HEIGHT:   r_cfg.rect_height   <= i_cfg_data[7:0];
                CFG_CORNER_RADIUS: r_cfg.corner_radius <= i_cfg_data[6:0];
                CFG_FILL_COLOR:    r_cfg.fill_color    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rrps_front #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_data    (i_data),
        .i_cfg     (r_cfg),
        .i_q_count (q_count),
        .o_push    (push),
        .o_entry   (entry)
    );

    rrps_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  (entry),
        .i_pop    (pop),
        .o_rdata  (head),
        .o_nempty (q_nempty),
        .o_count  (q_count)
    );

    rrps_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_nempty (q_nempty),
        .i_head     (head),
        .o_pop      (pop),
        .i_cfg      (r_cfg),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

endmodule

// File: sv/rrps_queue.sv
module rrps_queue
    import rrps_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  t_qent          i_wdata,
    input  logic           i_pop,
    output t_qent          o_rdata,
    output logic           o_nempty,
    output logic [QCW-1:0] o_count
);

    t_qent          r_mem [QDEPTH];
    logic [QAW-1:0] r_rd, r_wr;
    logic [QCW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    assign o_rdata  = r_mem[r_rd];
    assign o_nempty = (r_count != '0);
    assign o_count  = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_count == QCW'(QDEPTH)))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == '0))
        else $error("queue underflow");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count mismatch");

endmodule

// File: sv/rrps_front.sv
module rrps_front
    import rrps_pkg::*;
#(
    parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  t_in            i_data,
    input  t_cfg           i_cfg,
    input  logic [QCW-1:0] i_q_count,
    output logic           o_push,
    output t_qent          o_entry
);

    logic        r_v1;
    logic [15:0] r_sx0, r_sx1, r_sy0, r_sy1;
    logic [13:0] r_rr;
    logic        r_band, r_inrect, r_inb;
    logic [6:0]  r_px, r_py;

    logic              acc;
    logic signed [9:0] si, sj, sr, cx1, cy1, dx0, dx1, dy0, dy1;
    logic [7:0]        px8, py8;
    logic [16:0]       d0, d1, d2, d3, rr17, m01, m23, dmin;
    logic              in_shape, strict;

    assign o_stall = ({1'b0, i_q_count} + {{QCW{1'b0}}, r_v1}) >= (QCW+1)'(QDEPTH);
    assign acc     = i_valid && !o_stall;

    always_comb begin
        si  = {3'b0, i_data.col_offset};
        sj  = {3'b0, i_data.row_offset};
        sr  = {3'b0, i_cfg.corner_radius};
        cx1 = {2'b0, i_cfg.rect_width} - sr;
        cy1 = {2'b0, i_cfg.rect_height} - sr;
        dx0 = si - sr;
        dx1 = si - cx1;
        dy0 = sj - sr;
        dy1 = sj - cy1;
        px8 = {1'b0, i_cfg.rect_left} + {1'b0, i_data.col_offset};
        py8 = {1'b0, i_cfg.rect_top} + {1'b0, i_data.row_offset};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_sx0    <= 16'(dx0 * dx0);
            r_sx1    <= 16'(dx1 * dx1);
            r_sy0    <= 16'(dy0 * dy0);
            r_sy1    <= 16'(dy1 * dy1);
            r_rr     <= 14'(i_cfg.corner_radius * i_cfg.corner_radius);
            r_band   <= (si >= sr && si < cx1) || (sj >= sr && sj < cy1);
            r_inrect <= ({1'b0, i_data.col_offset} < i_cfg.rect_width) &&
                        ({1'b0, i_data.row_offset} < i_cfg.rect_height);
            r_inb    <= ({3'b0, px8} < CANVAS_CMP_W'(CANVAS_WIDTH)) &&
                        ({3'b0, py8} < CANVAS_CMP_W'(CANVAS_HEIGHT));
            r_px     <= px8[6:0];
            r_py     <= py8[6:0];
        end
    end

    always_comb begin
        d0   = {1'b0, r_sx0} + {1'b0, r_sy0};
        d1   = {1'b0, r_sx1} + {1'b0, r_sy0};
        d2   = {1'b0, r_sx0} + {1'b0, r_sy1};
        d3   = {1'b0, r_sx1} + {1'b0, r_sy1};
        rr17 = {3'b0, r_rr};
        in_shape = r_band || d0 <= rr17 || d1 <= rr17 || d2 <= rr17 || d3 <= rr17;
        strict = d0 < rr17 || d1 < rr17 || d2 < rr17 || d3 < rr17;
        m01  = (d1 < d0) ? d1 : d0;
        m23  = (d3 < d2) ? d3 : d2;
        dmin = (m23 < m01) ? m23 : m01;
        o_push        = r_v1 && r_inrect && in_shape && r_inb;
        o_entry.scale = strict && (i_cfg.corner_radius != '0);
        o_entry.alpha = i_cfg.fill_color[7:0];
        o_entry.dmin  = dmin[13:0];
        o_entry.px    = r_px;
        o_entry.py    = r_py;
    end

endmodule

// File: sv/rrps_back.sv
module rrps_back
    import rrps_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_nempty,
    input  t_qent i_head,
    output logic  o_pop,
    input  t_cfg  i_cfg,
    output logic  o_valid,
    input  logic  i_stall,
    output t_out  o_data
);

    localparam int NSQ    = 8;
    localparam int NDV    = 4;
    localparam int SQ0    = 2;
    localparam int DV0    = SQ0 + NSQ;
    localparam int NST    = DV0 + NDV + 1;
    localparam int SQ_TOP = 14;
    localparam int DV_TOP = 7;

    typedef struct packed {
        logic        scale;
        logic [7:0]  alpha;
        logic [13:0] dmin;
        logic [6:0]  px;
        logic [6:0]  py;
        logic [29:0] x;
        logic [16:0] rem;
        logic [14:0] root;
        logic [6:0]  drem;
        logic [7:0]  q;
    } t_bst;

    typedef struct packed {
        logic [16:0] rem;
        logic [14:0] root;
    } t_sq;

    typedef struct packed {
        logic [6:0] drem;
        logic       qb;
    } t_dv;

    function automatic t_sq sq_step(input logic [16:0] rem, input logic [14:0] root,
                                    input logic [1:0] pair);
        logic [18:0] t, trial;
        t_sq         o;
        t     = {rem, pair};
        trial = {2'b0, root, 2'b01};
        if (t >= trial) begin
            o.rem  = 17'(t - trial);
            o.root = {root[13:0], 1'b1};
        end else begin
            o.rem  = t[16:0];
            o.root = {root[13:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_dv dv_step(input logic [6:0] drem, input logic b,
                                    input logic [6:0] r);
        logic [7:0] t;
        t_dv        o;
        t = {drem, b};
        if (t >= {1'b0, r}) begin
            o.drem = 7'(t - {1'b0, r});
            o.qb   = 1'b1;
        end else begin
            o.drem = t[6:0];
            o.qb   = 1'b0;
        end
        return o;
    endfunction

    t_bst             r_st [NST];
    t_bst             n_st [NST];
    logic [NST-1:0]   r_v;
    logic             en;
    t_sq              sq;
    t_dv              dv;
    int               b;

    always_comb begin
        en    = !(r_v[NST-1] && i_stall);
        o_pop = i_q_nempty && en;
        sq    = '0;
        dv    = '0;
        b     = 0;
        for (int k = 0; k < NST; k++) begin
            if (k == 0) begin
                n_st[k]       = '0;
                n_st[k].scale = i_head.scale;
                n_st[k].alpha = i_head.alpha;
                n_st[k].dmin  = i_head.dmin;
                n_st[k].px    = i_head.px;
                n_st[k].py    = i_head.py;
                n_st[k].x     = 30'(16'(i_head.alpha * i_head.alpha));
            end else if (k == 1) begin
                n_st[k]      = r_st[k-1];
                n_st[k].x    = 30'(r_st[k-1].x[15:0] * r_st[k-1].dmin);
                n_st[k].rem  = '0;
                n_st[k].root = '0;
            end else if (k < DV0) begin
                n_st[k] = r_st[k-1];
                for (int t = 0; t < 2; t++) begin
                    b = SQ_TOP - 2 * (k - SQ0) - t;
                    if (b >= 0) begin
                        sq = sq_step(n_st[k].rem, n_st[k].root,
                                     2'(r_st[k-1].x >> (2 * b)));
                        n_st[k].rem  = sq.rem;
                        n_st[k].root = sq.root;
                    end
                end
            end else if (k < NST - 1) begin
                n_st[k] = r_st[k-1];
                if (k == DV0) begin
                    n_st[k].drem = r_st[k-1].root[14:8];
                    n_st[k].q    = '0;
                end
                for (int t = 0; t < 2; t++) begin
                    b  = DV_TOP - 2 * (k - DV0) - t;
                    dv = dv_step(n_st[k].drem, 1'(r_st[k-1].root >> b),
                                 i_cfg.corner_radius);
                    n_st[k].drem = dv.drem;
                    n_st[k].q    = {n_st[k].q[6:0], dv.qb};
                end
            end else begin
                n_st[k] = r_st[k-1];
                if (r_st[k-1].scale) begin
                    n_st[k].alpha = r_st[k-1].q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NST-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NST; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_valid      = r_v[NST-1];
    assign o_data.pix_x = r_st[NST-1].px;
    assign o_data.pix_y = r_st[NST-1].py;
    assign o_data.red   = i_cfg.fill_color[31:24];
    assign o_data.green = i_cfg.fill_color[23:16];
    assign o_data.blue  = i_cfg.fill_color[15:8];
    assign o_data.alpha = r_st[NST-1].alpha;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST-1] && i_stall) |=> r_v == $past(r_v))
        else $error("pipeline moved under stall");
    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST-1] && i_stall) |-> !o_pop)
        else $error("pop while stalled");
    a_scaled_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_st[NST-1].scale) |-> r_st[NST-1].q == r_st[NST-1].alpha)
        else $error("scaled alpha not selected");

endmodule
